// ===== rtl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

  localparam int DEF_HEAP_BYTES = 1024 * 1024;
  localparam int DEF_MAX_BLOCKS = 1024;

  localparam int HDR_BYTES = 8 + 1;
  localparam int REQ_W     = 21;
  localparam int OFFSET_W  = 20;
  // holds heap start + header + largest request at the largest heap
  localparam int ACC_W     = 26;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_REFUSED      = 2'd1,
    ST_BAD_OFFSET   = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [OFFSET_W-1:0] payload_offset;
    status_e             status;
  } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/ffha_req_if.sv =====
// ----------------------------------------------------------------------------
// ffha_req_if
// Request channel: alloc/free requests with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffha_req_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [ffha_pkg::REQ_W-1:0]     request_size;
  logic [ffha_pkg::OFFSET_W-1:0]  release_offset;

  modport source (output valid, output kind, output request_size,
                  output release_offset, input ready);
  modport sink   (input valid, input kind, input request_size,
                  input release_offset, output ready);
endinterface

`default_nettype wire

// ===== rtl/ffha_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ffha_rsp_if
// Response channel: granted offset and status with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffha_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [ffha_pkg::OFFSET_W-1:0]  payload_offset;
  logic [1:0]                     status;

  modport source (output valid, output payload_offset, output status, input ready);
  modport sink   (input valid, input payload_offset, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/ffha_table.sv =====
// ----------------------------------------------------------------------------
// ffha_table
// Block table RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_table #(
  parameter int DEPTH  = ffha_pkg::DEF_MAX_BLOCKS,
  parameter int DATA_W = 21,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output      logic [DATA_W-1:0] rd_data_o,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ffha_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffha_ctrl
// Walk sequencer: first-fit scan over the block table, one entry per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_ctrl #(
  parameter int HEAP_BYTES = ffha_pkg::DEF_HEAP_BYTES,
  parameter int MAX_BLOCKS = ffha_pkg::DEF_MAX_BLOCKS,
  parameter int IDX_W      = $clog2(MAX_BLOCKS),
  parameter int SIZE_W     = $clog2(HEAP_BYTES),
  parameter int DATA_W     = SIZE_W + 1
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  ffha_req_if.sink            req_i,
  output      logic           res_valid_o,
  input  wire logic           res_ready_i,
  output      ffha_pkg::rsp_t res_o,
  output      logic           rd_en_o,
  output      logic [IDX_W-1:0]  rd_addr_o,
  input  wire logic [DATA_W-1:0] rd_data_i,
  output      logic           wr_en_o,
  output      logic [IDX_W-1:0]  wr_addr_o,
  output      logic [DATA_W-1:0] wr_data_o
);

  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int HEND_W = $clog2(HEAP_BYTES + 1);
  localparam int ACC_W  = ffha_pkg::ACC_W;

  ffha_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0]  idx_q, idx_d, count_q, count_d, idx_nxt;
  logic [HEND_W-1:0] heap_end_q, heap_end_d;
  logic [ACC_W-1:0]  pay_q, pay_d;
  ffha_pkg::kind_e   kind_q, kind_d;
  logic [ffha_pkg::REQ_W-1:0]    req_q, req_d;
  logic [ffha_pkg::OFFSET_W-1:0] off_q, off_d;
  ffha_pkg::rsp_t    res_q, res_d;

  logic              accept, zero_alloc;
  logic              at_end, ent_used, fit, hit, over_scan, over_end, full, cont, scan_done;
  logic [SIZE_W-1:0] ent_size;
  logic [ACC_W-1:0]  req_ext, size_ext, end_pay, end_top;

  assign req_i.ready = (state_q == ffha_pkg::S_IDLE);
  assign res_valid_o = (state_q == ffha_pkg::S_RESP);

  assign accept     = req_i.valid && req_i.ready;
  assign zero_alloc = (ffha_pkg::kind_e'(req_i.kind) == ffha_pkg::KIND_ALLOC) &&
                      (req_i.request_size == '0);
  assign idx_nxt    = idx_q + 1'b1;

  assign ent_size  = rd_data_i[SIZE_W-1:0];
  assign ent_used  = rd_data_i[SIZE_W];
  assign req_ext   = ACC_W'(req_q);
  assign size_ext  = ACC_W'(ent_size);
  assign end_pay   = ACC_W'(heap_end_q) + ACC_W'(ffha_pkg::HDR_BYTES);
  assign end_top   = end_pay + req_ext;
  assign at_end    = (idx_q == count_q);
  assign fit       = !ent_used && (size_ext >= req_ext);
  assign hit       = (pay_q == ACC_W'(off_q));
  assign over_scan = (pay_q + req_ext) > ACC_W'(HEAP_BYTES);
  assign over_end  = end_top > ACC_W'(HEAP_BYTES);
  assign full      = (count_q >= CNT_W'(MAX_BLOCKS));
  assign cont      = !at_end && ((kind_q == ffha_pkg::KIND_ALLOC) ? (!over_scan && !fit)
                                                                  : !hit);
  assign scan_done = (state_q == ffha_pkg::S_SCAN) && !cont;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ffha_pkg::S_IDLE: begin
        if (accept) begin
          state_d = zero_alloc ? ffha_pkg::S_RESP : ffha_pkg::S_SCAN;
        end
      end
      ffha_pkg::S_SCAN: begin
        if (scan_done) begin
          state_d = ffha_pkg::S_RESP;
        end
      end
      ffha_pkg::S_RESP: begin
        if (res_ready_i) begin
          state_d = ffha_pkg::S_IDLE;
        end
      end
      default: state_d = ffha_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    idx_d      = idx_q;
    count_d    = count_q;
    heap_end_d = heap_end_q;
    pay_d      = pay_q;
    kind_d     = kind_q;
    req_d      = req_q;
    off_d      = off_q;
    res_d      = res_q;
    rd_en_o    = 1'b0;
    rd_addr_o  = idx_nxt[IDX_W-1:0];
    wr_en_o    = 1'b0;
    wr_addr_o  = idx_q[IDX_W-1:0];
    wr_data_o  = {1'b1, ent_size};
    case (state_q)
      ffha_pkg::S_IDLE: begin
        if (accept) begin
          kind_d    = ffha_pkg::kind_e'(req_i.kind);
          req_d     = req_i.request_size;
          off_d     = req_i.release_offset;
          idx_d     = '0;
          pay_d     = ACC_W'(ffha_pkg::HDR_BYTES);
          rd_en_o   = 1'b1;
          rd_addr_o = '0;
          res_d     = '{payload_offset: '0, status: ffha_pkg::ST_REFUSED};
        end
      end
      ffha_pkg::S_SCAN: begin
        res_d = '{payload_offset: '0, status: ffha_pkg::ST_REFUSED};
        if (cont) begin
          idx_d   = idx_nxt;
          pay_d   = pay_q + size_ext + ACC_W'(ffha_pkg::HDR_BYTES);
          rd_en_o = 1'b1;
        end else if (kind_q == ffha_pkg::KIND_ALLOC) begin
          if (at_end) begin
            if (!over_end && !full) begin
              wr_en_o    = 1'b1;
              wr_addr_o  = count_q[IDX_W-1:0];
              wr_data_o  = {1'b1, SIZE_W'(req_q)};
              count_d    = count_q + 1'b1;
              heap_end_d = HEND_W'(end_top);
              res_d      = '{payload_offset: end_pay[ffha_pkg::OFFSET_W-1:0],
                             status: ffha_pkg::ST_OK};
            end
          end else if (!over_scan) begin
            wr_en_o = 1'b1;
            res_d   = '{payload_offset: pay_q[ffha_pkg::OFFSET_W-1:0],
                        status: ffha_pkg::ST_OK};
          end
        end else begin
          if (at_end) begin
            res_d.status = ffha_pkg::ST_BAD_OFFSET;
          end else if (ent_used) begin
            wr_en_o      = 1'b1;
            wr_data_o    = {1'b0, ent_size};
            res_d.status = ffha_pkg::ST_OK;
          end else begin
            res_d.status = ffha_pkg::ST_ALREADY_FREE;
          end
        end
      end
      default: ;
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ffha_pkg::S_IDLE;
      idx_q      <= '0;
      count_q    <= '0;
      heap_end_q <= '0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      count_q    <= count_d;
      heap_end_q <= heap_end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q  <= pay_d;
    kind_q <= kind_d;
    req_q  <= req_d;
    off_q  <= off_d;
    res_q  <= res_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_BLOCKS))
    else $error("block count above table depth");

  a_scan_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ffha_pkg::S_SCAN |-> idx_q <= count_q)
    else $error("scan index past block count");

  a_wr_ends_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |=> state_q == ffha_pkg::S_RESP)
    else $error("table write without finishing the walk");

  a_heap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    heap_end_q <= HEND_W'(HEAP_BYTES))
    else $error("heap end beyond heap");

endmodule

`default_nettype wire

// ===== rtl/first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with an implicit block list in a table RAM.
//
// req_i carries alloc (kind 0, request_size) and free (kind 1,
// release_offset) requests; rsp_o returns one response per request with
// payload_offset and status. Both use valid/ready.
// One request is processed at a time. A request walks the block table from
// entry 0, one entry per cycle (registered RAM read), until an entry ends
// the walk or it reaches the end of the block list. A zero-size alloc is
// answered without a walk. A new request is taken once the walker has
// passed its previous result on to the output register.
// The response sits in an output register; the walker can finish the next
// request while it waits, and holds that result until the register frees.
// Reset empties the heap (block count and heap end go to zero); the table
// RAM is not cleared, and entries past the block count are never used.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator #(
  parameter int HEAP_BYTES = ffha_pkg::DEF_HEAP_BYTES,
  parameter int MAX_BLOCKS = ffha_pkg::DEF_MAX_BLOCKS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ffha_req_if.sink   req_i,
  ffha_rsp_if.source rsp_o
);

  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int SIZE_W = $clog2(HEAP_BYTES);
  localparam int DATA_W = SIZE_W + 1;

  logic              res_valid, res_ready;
  ffha_pkg::rsp_t    res, out_q;
  logic              out_valid_q;
  logic              rd_en, wr_en;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic [DATA_W-1:0] rd_data, wr_data;

  ffha_ctrl #(
    .HEAP_BYTES (HEAP_BYTES),
    .MAX_BLOCKS (MAX_BLOCKS),
    .IDX_W      (IDX_W),
    .SIZE_W     (SIZE_W),
    .DATA_W     (DATA_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  ffha_table #(
    .DEPTH  (MAX_BLOCKS),
    .DATA_W (DATA_W),
    .ADDR_W (IDX_W)
  ) u_table (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.payload_offset = out_q.payload_offset;
  assign rsp_o.status         = out_q.status;

endmodule

`default_nettype wire
